[src/hmmb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmb_pkg
// Types, constants and item formats shared by the memory map bus modules.
// ----------------------------------------------------------------------------
package hmmb_pkg;

  localparam int SpriteBytes = 160;
  localparam int VideoBytes  = 8192;
  localparam int WorkBytes   = 8192;
  localparam int HighBytes   = 127;

  localparam int VideoAw  = $clog2(VideoBytes);
  localparam int WorkAw   = $clog2(WorkBytes);
  localparam int SpriteAw = $clog2(SpriteBytes);
  localparam int HighAw   = $clog2(HighBytes);
  localparam int IndexW   = (VideoAw > WorkAw) ? VideoAw : WorkAw;
  localparam int ClearW   = IndexW;
  localparam int DmaCntW  = $clog2(SpriteBytes + 1);
  localparam int DmaPageW = IndexW - SpriteAw;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [ClearW-1:0]  ClearLast     = ClearW'(VideoBytes - 1);
  localparam logic [DmaCntW-1:0] DmaCntLast    = DmaCntW'(SpriteBytes);

  localparam logic [15:0] AddrCartLoEnd  = 16'h7FFF;
  localparam logic [15:0] AddrVideoEnd   = 16'h9FFF;
  localparam logic [15:0] AddrCartHiEnd  = 16'hBFFF;
  localparam logic [15:0] AddrEchoEnd    = 16'hFDFF;
  localparam logic [15:0] AddrSpriteEnd  = 16'hFE9F;
  localparam logic [15:0] AddrUnusedEnd  = 16'hFEFF;
  localparam logic [15:0] AddrJoypad     = 16'hFF00;
  localparam logic [15:0] AddrTimerLo    = 16'hFF04;
  localparam logic [15:0] AddrTimerHi    = 16'hFF07;
  localparam logic [15:0] AddrIrqFlags   = 16'hFF0F;
  localparam logic [15:0] AddrAudioLo    = 16'hFF10;
  localparam logic [15:0] AddrAudioHi    = 16'hFF3F;
  localparam logic [15:0] AddrLcdLo      = 16'hFF40;
  localparam logic [15:0] AddrLcdHi      = 16'hFF4B;
  localparam logic [15:0] AddrDma        = 16'hFF46;
  localparam logic [15:0] AddrHighLo     = 16'hFF80;
  localparam logic [15:0] AddrHighHi     = 16'hFFFE;
  localparam logic [15:0] AddrIrqEnable  = 16'hFFFF;

  localparam logic [7:0] PageVideoLo  = 8'h80;
  localparam logic [7:0] PageVideoHi  = 8'h9F;
  localparam logic [7:0] PageWorkLo   = 8'hC0;
  localparam logic [7:0] PageSprite   = 8'hFE;
  localparam logic [2:0] PageVideoTop = 3'b100;

  localparam logic [7:0] IrqFlagsHigh = 8'hE0;
  localparam logic [4:0] IrqReqMask   = 5'h17;
  localparam logic [7:0] UnmappedByte = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RT_INTERNAL = 3'd0,
    RT_CART     = 3'd1,
    RT_AUDIO    = 3'd2,
    RT_VIDEO    = 3'd3,
    RT_JOYPAD   = 3'd4,
    RT_TIMER    = 3'd5,
    RT_UNMAPPED = 3'd6
  } route_e;

  typedef enum logic [2:0] {
    RG_EXT,
    RG_VRAM,
    RG_WRAM,
    RG_OAM,
    RG_HRAM,
    RG_IF,
    RG_IE,
    RG_UNUSED
  } region_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_COPY
  } back_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  device_read_data;
    logic [4:0]  irq_requests;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] route;
    logic       dma_copied;
    logic [7:0] enable_mask;
    logic [7:0] flag_bits;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    region_e           region;
    route_e            route;
    logic [IndexW-1:0] index;
    logic [7:0]        wdata;
    logic [7:0]        dev;
    logic [4:0]        req;
    logic              dma_hit;
    logic              dma_go;
  } cmd_t;

endpackage

[src/hmmb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmb_front
// Accepts bus items and classifies them against the memory map.
// ----------------------------------------------------------------------------
module hmmb_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hmmb_pkg::in_item_t   in_data_i,
  input  logic                 q_full_i,
  input  logic                 clearing_i,
  output logic                 push_o,
  output hmmb_pkg::cmd_t       cmd_o
);

  logic [15:0] addr;
  logic [7:0]  page;
  logic        page_int;

  assign in_stall_o = q_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    addr     = in_data_i.address;
    page     = in_data_i.write_data;
    page_int = ((page >= hmmb_pkg::PageVideoLo) && (page <= hmmb_pkg::PageVideoHi)) ||
               ((page >= hmmb_pkg::PageWorkLo) && (page <= hmmb_pkg::PageSprite));

    cmd_o.op      = hmmb_pkg::op_e'(in_data_i.opcode);
    cmd_o.region  = hmmb_pkg::RG_UNUSED;
    cmd_o.route   = hmmb_pkg::RT_UNMAPPED;
    cmd_o.index   = '0;
    cmd_o.wdata   = in_data_i.write_data;
    cmd_o.dev     = in_data_i.device_read_data;
    cmd_o.req     = in_data_i.irq_requests & hmmb_pkg::IrqReqMask;

    priority if (addr <= hmmb_pkg::AddrCartLoEnd) begin
      cmd_o.region = hmmb_pkg::RG_EXT;
      cmd_o.route  = hmmb_pkg::RT_CART;
    end else if (addr <= hmmb_pkg::AddrVideoEnd) begin
      cmd_o.region = hmmb_pkg::RG_VRAM;
      cmd_o.route  = hmmb_pkg::RT_INTERNAL;
      cmd_o.index  = addr[hmmb_pkg::IndexW-1:0];
    end else if (addr <= hmmb_pkg::AddrCartHiEnd) begin
      cmd_o.region = hmmb_pkg::RG_EXT;
      cmd_o.route  = hmmb_pkg::RT_CART;
    end else if (addr <= hmmb_pkg::AddrEchoEnd) begin
      cmd_o.region = hmmb_pkg::RG_WRAM;
      cmd_o.route  = hmmb_pkg::RT_INTERNAL;
      cmd_o.index  = addr[hmmb_pkg::IndexW-1:0];
    end else if (addr <= hmmb_pkg::AddrSpriteEnd) begin
      cmd_o.region = hmmb_pkg::RG_OAM;
      cmd_o.route  = hmmb_pkg::RT_INTERNAL;
      cmd_o.index  = hmmb_pkg::IndexW'(addr[7:0]);
    end else if (addr <= hmmb_pkg::AddrUnusedEnd) begin
      cmd_o.region = hmmb_pkg::RG_UNUSED;
      cmd_o.route  = hmmb_pkg::RT_UNMAPPED;
    end else if (addr >= hmmb_pkg::AddrAudioLo && addr <= hmmb_pkg::AddrAudioHi) begin
      cmd_o.region = hmmb_pkg::RG_EXT;
      cmd_o.route  = hmmb_pkg::RT_AUDIO;
    end else if (addr >= hmmb_pkg::AddrLcdLo && addr <= hmmb_pkg::AddrLcdHi) begin
      cmd_o.region = hmmb_pkg::RG_EXT;
      cmd_o.route  = hmmb_pkg::RT_VIDEO;
    end else if (addr == hmmb_pkg::AddrJoypad) begin
      cmd_o.region = hmmb_pkg::RG_EXT;
      cmd_o.route  = hmmb_pkg::RT_JOYPAD;
    end else if (addr >= hmmb_pkg::AddrTimerLo && addr <= hmmb_pkg::AddrTimerHi) begin
      cmd_o.region = hmmb_pkg::RG_EXT;
      cmd_o.route  = hmmb_pkg::RT_TIMER;
    end else if (addr == hmmb_pkg::AddrIrqFlags) begin
      cmd_o.region = hmmb_pkg::RG_IF;
      cmd_o.route  = hmmb_pkg::RT_INTERNAL;
    end else if (addr == hmmb_pkg::AddrIrqEnable) begin
      cmd_o.region = hmmb_pkg::RG_IE;
      cmd_o.route  = hmmb_pkg::RT_INTERNAL;
    end else if (addr >= hmmb_pkg::AddrHighLo && addr <= hmmb_pkg::AddrHighHi) begin
      cmd_o.region = hmmb_pkg::RG_HRAM;
      cmd_o.route  = hmmb_pkg::RT_INTERNAL;
      cmd_o.index  = hmmb_pkg::IndexW'(addr[hmmb_pkg::HighAw-1:0]);
    end else begin
      cmd_o.region = hmmb_pkg::RG_UNUSED;
      cmd_o.route  = hmmb_pkg::RT_UNMAPPED;
    end

    // sprite page copies onto itself: reported, nothing moves
    cmd_o.dma_hit = (in_data_i.opcode == hmmb_pkg::OP_WRITE) &&
                    (addr == hmmb_pkg::AddrDma) && page_int;
    cmd_o.dma_go  = cmd_o.dma_hit && (page != hmmb_pkg::PageSprite);
  end

endmodule

[src/hmmb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmb_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module hmmb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hmmb_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hmmb_pkg::cmd_t cmd_o
);

  hmmb_pkg::cmd_t                   entries_q [hmmb_pkg::QueueDepth];
  logic [hmmb_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [hmmb_pkg::QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [hmmb_pkg::QueueCntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == hmmb_pkg::QueueCntW'(hmmb_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hmmb_pkg::QueuePtrW'(hmmb_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hmmb_pkg::QueuePtrW'(hmmb_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[src/hmmb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmmb_back
// Carries out classified items: RAMs, interrupt registers, sprite copy,
// power-up clearing and the output register.
// ----------------------------------------------------------------------------
module hmmb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  hmmb_pkg::cmd_t        q_cmd_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output hmmb_pkg::out_item_t   out_data_o
);

  hmmb_pkg::back_state_e state_q, state_d;

  logic [hmmb_pkg::ClearW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [hmmb_pkg::DmaCntW-1:0]  dma_cnt_q, dma_cnt_d;
  logic [hmmb_pkg::DmaPageW-1:0] dma_page_q, dma_page_d;
  logic                          dma_vram_q, dma_vram_d;
  logic                          dma_wr_q, dma_wr_d;
  logic [hmmb_pkg::SpriteAw-1:0] dma_wr_idx_q, dma_wr_idx_d;

  logic [7:0] ie_q, ie_d;
  logic [7:0] if_q, if_d;

  logic                  out_valid_q;
  hmmb_pkg::region_e     res_sel_q, res_sel_d;
  logic [7:0]            res_data_q, res_data_d;
  hmmb_pkg::route_e      res_route_q, res_route_d;
  logic                  res_copied_q, res_copied_d;

  logic fire, clearing, copying, dma_rd, is_rd, is_wr;

  logic [7:0] vram_mem [hmmb_pkg::VideoBytes];
  logic [7:0] wram_mem [hmmb_pkg::WorkBytes];
  logic [7:0] oam_mem  [hmmb_pkg::SpriteBytes];
  logic [7:0] hram_mem [hmmb_pkg::HighBytes];

  logic                          vram_we, vram_re;
  logic [hmmb_pkg::VideoAw-1:0]  vram_wa, vram_ra;
  logic [7:0]                    vram_wd, vram_rd_q;
  logic                          wram_we, wram_re;
  logic [hmmb_pkg::WorkAw-1:0]   wram_wa, wram_ra;
  logic [7:0]                    wram_wd, wram_rd_q;
  logic                          oam_we, oam_re;
  logic [hmmb_pkg::SpriteAw-1:0] oam_wa;
  logic [7:0]                    oam_wd, oam_rd_q;
  logic                          hram_we, hram_re;
  logic [hmmb_pkg::HighAw-1:0]   hram_wa;
  logic [7:0]                    hram_wd, hram_rd_q;
  logic [hmmb_pkg::IndexW-1:0]   dma_src;

  assign clearing   = (state_q == hmmb_pkg::BK_CLEAR);
  assign copying    = (state_q == hmmb_pkg::BK_COPY);
  assign clearing_o = clearing;
  assign fire       = (state_q == hmmb_pkg::BK_RUN) && q_valid_i &&
                      (!out_valid_q || !out_stall_i);
  assign pop_o      = fire;
  assign is_rd      = fire && (q_cmd_i.op == hmmb_pkg::OP_READ);
  assign is_wr      = fire && (q_cmd_i.op == hmmb_pkg::OP_WRITE);
  assign dma_rd     = copying && (dma_cnt_q < hmmb_pkg::DmaCntLast);
  assign dma_src    = {dma_page_q, dma_cnt_q[hmmb_pkg::SpriteAw-1:0]};

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    dma_cnt_d    = dma_cnt_q;
    dma_page_d   = dma_page_q;
    dma_vram_d   = dma_vram_q;
    dma_wr_d     = 1'b0;
    dma_wr_idx_d = dma_wr_idx_q;
    ie_d         = ie_q;
    if_d         = if_q;
    res_sel_d    = hmmb_pkg::RG_UNUSED;
    res_data_d   = '0;
    res_route_d  = hmmb_pkg::RT_INTERNAL;
    res_copied_d = 1'b0;

    unique case (state_q)
      hmmb_pkg::BK_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == hmmb_pkg::ClearLast) begin
          state_d = hmmb_pkg::BK_RUN;
        end
      end
      hmmb_pkg::BK_RUN: begin
        if (fire && q_cmd_i.dma_go) begin
          state_d    = hmmb_pkg::BK_COPY;
          dma_cnt_d  = '0;
          dma_page_d = q_cmd_i.wdata[hmmb_pkg::DmaPageW-1:0];
          dma_vram_d = (q_cmd_i.wdata[7:5] == hmmb_pkg::PageVideoTop);
        end
      end
      hmmb_pkg::BK_COPY: begin
        dma_cnt_d    = dma_cnt_q + 1'b1;
        dma_wr_d     = dma_rd;
        dma_wr_idx_d = dma_cnt_q[hmmb_pkg::SpriteAw-1:0];
        if (dma_cnt_q == hmmb_pkg::DmaCntLast) begin
          state_d = hmmb_pkg::BK_RUN;
        end
      end
      default: begin
        state_d = hmmb_pkg::BK_CLEAR;
      end
    endcase

    if (is_wr && q_cmd_i.region == hmmb_pkg::RG_IE) begin
      ie_d = q_cmd_i.wdata;
    end
    if (is_wr && q_cmd_i.region == hmmb_pkg::RG_IF) begin
      if_d = q_cmd_i.wdata | hmmb_pkg::IrqFlagsHigh;
    end else if (fire && q_cmd_i.op == hmmb_pkg::OP_TICK) begin
      if_d = if_q | {3'b000, q_cmd_i.req};
    end

    if (is_rd || is_wr) begin
      res_route_d = q_cmd_i.route;
    end
    if (is_rd) begin
      res_sel_d = q_cmd_i.region;
      unique case (q_cmd_i.region)
        hmmb_pkg::RG_IF:     res_data_d = if_q | hmmb_pkg::IrqFlagsHigh;
        hmmb_pkg::RG_IE:     res_data_d = ie_q;
        hmmb_pkg::RG_UNUSED: res_data_d = hmmb_pkg::UnmappedByte;
        hmmb_pkg::RG_EXT:    res_data_d = q_cmd_i.dev;
        default:             res_data_d = '0;
      endcase
    end
    res_copied_d = is_wr && q_cmd_i.dma_hit;
  end

  // memory ports
  always_comb begin
    vram_we = clearing || (is_wr && q_cmd_i.region == hmmb_pkg::RG_VRAM);
    vram_wa = clearing ? clr_cnt_q[hmmb_pkg::VideoAw-1:0] :
                         q_cmd_i.index[hmmb_pkg::VideoAw-1:0];
    vram_wd = clearing ? 8'h00 : q_cmd_i.wdata;
    vram_re = (is_rd && q_cmd_i.region == hmmb_pkg::RG_VRAM) || (dma_rd && dma_vram_q);
    vram_ra = copying ? dma_src[hmmb_pkg::VideoAw-1:0] :
                        q_cmd_i.index[hmmb_pkg::VideoAw-1:0];

    wram_we = clearing || (is_wr && q_cmd_i.region == hmmb_pkg::RG_WRAM);
    wram_wa = clearing ? clr_cnt_q[hmmb_pkg::WorkAw-1:0] :
                         q_cmd_i.index[hmmb_pkg::WorkAw-1:0];
    wram_wd = clearing ? 8'h00 : q_cmd_i.wdata;
    wram_re = (is_rd && q_cmd_i.region == hmmb_pkg::RG_WRAM) || (dma_rd && !dma_vram_q);
    wram_ra = copying ? dma_src[hmmb_pkg::WorkAw-1:0] :
                        q_cmd_i.index[hmmb_pkg::WorkAw-1:0];

    oam_we = (clearing && clr_cnt_q < hmmb_pkg::ClearW'(hmmb_pkg::SpriteBytes)) ||
             dma_wr_q || (is_wr && q_cmd_i.region == hmmb_pkg::RG_OAM);
    oam_re = is_rd && q_cmd_i.region == hmmb_pkg::RG_OAM;
    priority if (clearing) begin
      oam_wa = clr_cnt_q[hmmb_pkg::SpriteAw-1:0];
      oam_wd = 8'h00;
    end else if (dma_wr_q) begin
      oam_wa = dma_wr_idx_q;
      oam_wd = dma_vram_q ? vram_rd_q : wram_rd_q;
    end else begin
      oam_wa = q_cmd_i.index[hmmb_pkg::SpriteAw-1:0];
      oam_wd = q_cmd_i.wdata;
    end

    hram_we = (clearing && clr_cnt_q < hmmb_pkg::ClearW'(hmmb_pkg::HighBytes)) ||
              (is_wr && q_cmd_i.region == hmmb_pkg::RG_HRAM);
    hram_re = is_rd && q_cmd_i.region == hmmb_pkg::RG_HRAM;
    hram_wa = clearing ? clr_cnt_q[hmmb_pkg::HighAw-1:0] :
                         q_cmd_i.index[hmmb_pkg::HighAw-1:0];
    hram_wd = clearing ? 8'h00 : q_cmd_i.wdata;
  end

  always_ff @(posedge clk_i) begin
    if (vram_we) begin
      vram_mem[vram_wa] <= vram_wd;
    end
    if (vram_re) begin
      vram_rd_q <= vram_mem[vram_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wram_we) begin
      wram_mem[wram_wa] <= wram_wd;
    end
    if (wram_re) begin
      wram_rd_q <= wram_mem[wram_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (oam_we) begin
      oam_mem[oam_wa] <= oam_wd;
    end
    if (oam_re) begin
      oam_rd_q <= oam_mem[q_cmd_i.index[hmmb_pkg::SpriteAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hram_we) begin
      hram_mem[hram_wa] <= hram_wd;
    end
    if (hram_re) begin
      hram_rd_q <= hram_mem[q_cmd_i.index[hmmb_pkg::HighAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hmmb_pkg::BK_CLEAR;
      clr_cnt_q   <= '0;
      dma_cnt_q   <= '0;
      dma_wr_q    <= 1'b0;
      ie_q        <= '0;
      if_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      dma_cnt_q   <= dma_cnt_d;
      dma_wr_q    <= dma_wr_d;
      ie_q        <= ie_d;
      if_q        <= if_d;
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    dma_page_q   <= dma_page_d;
    dma_vram_q   <= dma_vram_d;
    dma_wr_idx_q <= dma_wr_idx_d;
    if (fire) begin
      res_sel_q    <= res_sel_d;
      res_data_q   <= res_data_d;
      res_route_q  <= res_route_d;
      res_copied_q <= res_copied_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    unique case (res_sel_q)
      hmmb_pkg::RG_VRAM: out_data_o.read_data = vram_rd_q;
      hmmb_pkg::RG_WRAM: out_data_o.read_data = wram_rd_q;
      hmmb_pkg::RG_OAM:  out_data_o.read_data = oam_rd_q;
      hmmb_pkg::RG_HRAM: out_data_o.read_data = hram_rd_q;
      default:           out_data_o.read_data = res_data_q;
    endcase
    out_data_o.route       = res_route_q;
    out_data_o.dma_copied  = res_copied_q;
    out_data_o.enable_mask = ie_q;
    out_data_o.flag_bits   = if_q;
  end

endmodule

[src/handheld_memory_map_bus.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_memory_map_bus
// Memory map decoder of an 8-bit handheld CPU bus with sprite RAM copy.
// ----------------------------------------------------------------------------
// Reads, writes and ticks are taken one per cycle while in_stall_o is low and
// answered in order, one result per item; each result passes through the
// queue entry and then the output register. After reset the block zeroes
// video, work, sprite and high RAM (one address of each per cycle until that
// RAM is covered) and holds in_stall_o high meanwhile. A write to 0xFF46 with a
// video or work RAM source page returns its result at once and then occupies
// the execution side while the 160 sprite bytes move through the source RAM's
// read port; items arriving then wait in the two-entry queue.
module handheld_memory_map_bus (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hmmb_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hmmb_pkg::out_item_t  out_data_o
);

  hmmb_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, q_full, q_valid, clearing;

  hmmb_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  hmmb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  hmmb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
